// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros used by altitude_color_ramp
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define ACR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("altitude_color_ramp: assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define ACR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("altitude_color_ramp: assertion failed");

`endif

// ===== hw/rtl/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// widths, register indexes and types of the altitude color ramp
// ----------------------------------------------------------------------------
package acr_pkg;

	localparam int NUM_STOPS   = 6;
	localparam int ALT_W       = 16;
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = 3;
	localparam int COLOR_W     = CHAN_W * NUM_CHAN;
	localparam int STOP_W      = ALT_W + COLOR_W;
	localparam int CNT_W       = 3;
	localparam int IDX_W       = 3;
	localparam int CFG_INDEX_W = 4;
	localparam int OUT_FIELD_W = COLOR_W + IDX_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_WATER_LEVEL = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_STOP_COUNT  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STOP_BASE   = 4'd2;

	typedef logic [STOP_W-1:0]    stop_t;
	typedef logic [NUM_STOPS-1:0] stop_sel_t;

endpackage

// ===== hw/rtl/altitude_color_ramp.sv =====
// ----------------------------------------------------------------------------
// altitude_color_ramp
// maps a signed Q8.8 altitude, less the water level, onto a six-stop color ramp
// ----------------------------------------------------------------------------
// One pixel altitude enters per cycle and one RGB item with the lower stop index
// leaves per cycle while the output does not stall. Three stages find the height,
// compare it with every stop and pick the segment, then the blend fraction divider,
// a restoring divider, takes one stage per quotient bit, and three more stages
// select the stop colors, multiply and add. A stall on the output holds the whole
// pipeline in place. Configuration writes are taken in any cycle (cfg_ready is
// always high) but must only come while no item is in flight.
`include "assert_macros.svh"

module altitude_color_ramp #(
	parameter int FRAC_BITS = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [acr_pkg::ALT_W-1:0]          s_axis_tdata,  // altitude
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [acr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // red, green, blue, lower_stop
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [acr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [acr_pkg::STOP_W-1:0]         cfg_data
);
	import acr_pkg::*;

	localparam int H_W    = ALT_W + 1;
	localparam int D_W    = CHAN_W + 1;
	localparam int PROD_W = D_W + FRAC_BITS + 1;

	// configuration registers
	logic [ALT_W-1:0] water_level_q;
	logic [CNT_W-1:0] stop_count_q;
	stop_t            stop_q [NUM_STOPS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_level_q <= '0;
			stop_count_q  <= CNT_W'(1);
			for (int k = 0; k < NUM_STOPS; k++) begin
				stop_q[k] <= '0;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WATER_LEVEL: water_level_q <= cfg_data[ALT_W-1:0];
				REG_STOP_COUNT:  stop_count_q  <= cfg_data[CNT_W-1:0];
				default: begin
					for (int k = 0; k < NUM_STOPS; k++) begin
						if (cfg_index == CFG_INDEX_W'(REG_STOP_BASE + k)) begin
							stop_q[k] <= cfg_data;
						end
					end
				end
			endcase
		end
	end

	logic signed [H_W-1:0] stop_alt [NUM_STOPS];

	always_comb begin
		for (int k = 0; k < NUM_STOPS; k++) begin
			stop_alt[k] = $signed({stop_q[k][STOP_W-1], stop_q[k][STOP_W-1 -: ALT_W]});
		end
	end

	// whole pipeline moves when the output register is free
	logic adv;
	logic valid_s7;
	assign adv           = !valid_s7 || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: height above water
	logic                  valid_s1;
	logic signed [H_W-1:0] h_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s1 <= $signed({s_axis_tdata[ALT_W-1], s_axis_tdata})
				- $signed({water_level_q[ALT_W-1], water_level_q});
		end
	end

	// stage 2: compare against every stop
	logic                  valid_s2;
	logic signed [H_W-1:0] h_s2;
	stop_sel_t             ge_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			h_s2 <= h_s1;
			for (int k = 0; k < NUM_STOPS; k++) begin
				ge_s2[k] <= (h_s1 >= stop_alt[k]);
			end
		end
	end

	// stage 3: pick the segment, progress and gap
	logic [CNT_W-1:0]      count_eff;
	stop_sel_t             lo_oh;
	stop_sel_t             hi_oh;
	logic [IDX_W-1:0]      lo_idx;
	logic                  in_seg;
	logic signed [H_W-1:0] alt_lo;
	logic signed [H_W-1:0] alt_hi;
	logic signed [H_W-1:0] prog_full;
	logic signed [H_W-1:0] gap_full;

	always_comb begin
		if (stop_count_q == '0) begin
			count_eff = CNT_W'(1);
		end else if (stop_count_q > CNT_W'(NUM_STOPS)) begin
			count_eff = CNT_W'(NUM_STOPS);
		end else begin
			count_eff = stop_count_q;
		end
	end

	always_comb begin
		lo_idx = IDX_W'(count_eff - CNT_W'(1));
		in_seg = 1'b0;
		for (int k = 0; k < NUM_STOPS; k++) begin
			lo_oh[k] = (IDX_W'(k) == lo_idx);
		end
		hi_oh = lo_oh;
		// lowest stop above the height wins
		for (int j = NUM_STOPS - 1; j >= 1; j--) begin
			if ((CNT_W'(j) < count_eff) && !ge_s2[j]) begin
				lo_oh        = '0;
				hi_oh        = '0;
				lo_oh[j - 1] = 1'b1;
				hi_oh[j]     = 1'b1;
				lo_idx       = IDX_W'(j - 1);
				in_seg       = 1'b1;
			end
		end
		// below the first stop
		if (!ge_s2[0]) begin
			lo_oh    = '0;
			lo_oh[0] = 1'b1;
			hi_oh    = lo_oh;
			lo_idx   = '0;
			in_seg   = 1'b0;
		end
	end

	always_comb begin
		alt_lo = '0;
		alt_hi = '0;
		for (int k = 0; k < NUM_STOPS; k++) begin
			if (lo_oh[k]) alt_lo = alt_lo | stop_alt[k];
			if (hi_oh[k]) alt_hi = alt_hi | stop_alt[k];
		end
		prog_full = h_s2 - alt_lo;
		gap_full  = alt_hi - alt_lo;
	end

	logic             valid_s3;
	stop_sel_t        lo_oh_s3;
	stop_sel_t        hi_oh_s3;
	logic [IDX_W-1:0] lo_idx_s3;
	logic [ALT_W-1:0] prog_s3;
	logic [ALT_W-1:0] gap_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_oh_s3  <= lo_oh;
			hi_oh_s3  <= hi_oh;
			lo_idx_s3 <= lo_idx;
			// outside a segment the divider sees 0 / 1 and gives a zero fraction
			prog_s3   <= in_seg ? prog_full[ALT_W-1:0] : '0;
			gap_s3    <= in_seg ? gap_full[ALT_W-1:0] : ALT_W'(1);
		end
	end

	// stages 4 .. 3 + FRAC_BITS: restoring divider, one quotient bit per stage
	logic                 div_vld_s4    [FRAC_BITS];
	logic [ALT_W-1:0]     div_rem_s4    [FRAC_BITS];
	logic [ALT_W-1:0]     div_gap_s4    [FRAC_BITS];
	logic [FRAC_BITS-1:0] div_quo_s4    [FRAC_BITS];
	stop_sel_t            div_lo_oh_s4  [FRAC_BITS];
	stop_sel_t            div_hi_oh_s4  [FRAC_BITS];
	logic [IDX_W-1:0]     div_lo_idx_s4 [FRAC_BITS];

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
		logic                 vld_in;
		logic [ALT_W-1:0]     rem_in;
		logic [ALT_W-1:0]     gap_in;
		logic [FRAC_BITS-1:0] quo_in;
		stop_sel_t            lo_oh_in;
		stop_sel_t            hi_oh_in;
		logic [IDX_W-1:0]     lo_idx_in;
		logic [ALT_W:0]       rem_dbl;
		logic                 take;

		if (i == 0) begin : g_first
			assign vld_in    = valid_s3;
			assign rem_in    = prog_s3;
			assign gap_in    = gap_s3;
			assign quo_in    = '0;
			assign lo_oh_in  = lo_oh_s3;
			assign hi_oh_in  = hi_oh_s3;
			assign lo_idx_in = lo_idx_s3;
		end else begin : g_rest
			assign vld_in    = div_vld_s4[i-1];
			assign rem_in    = div_rem_s4[i-1];
			assign gap_in    = div_gap_s4[i-1];
			assign quo_in    = div_quo_s4[i-1];
			assign lo_oh_in  = div_lo_oh_s4[i-1];
			assign hi_oh_in  = div_hi_oh_s4[i-1];
			assign lo_idx_in = div_lo_idx_s4[i-1];
		end

		assign rem_dbl = {rem_in, 1'b0};
		assign take    = (rem_dbl >= {1'b0, gap_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld_s4[i] <= 1'b0;
			end else if (adv) begin
				div_vld_s4[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s4[i]    <= take ? ALT_W'(rem_dbl - {1'b0, gap_in}) : rem_dbl[ALT_W-1:0];
				div_gap_s4[i]    <= gap_in;
				div_quo_s4[i]    <= {quo_in[FRAC_BITS-2:0], take};
				div_lo_oh_s4[i]  <= lo_oh_in;
				div_hi_oh_s4[i]  <= hi_oh_in;
				div_lo_idx_s4[i] <= lo_idx_in;
			end
		end
	end

	// stage 5: stop colors and channel differences
	logic [CHAN_W-1:0] c_lo [NUM_CHAN];
	logic [CHAN_W-1:0] c_hi [NUM_CHAN];

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			c_lo[c] = '0;
			c_hi[c] = '0;
			for (int k = 0; k < NUM_STOPS; k++) begin
				if (div_lo_oh_s4[FRAC_BITS-1][k]) begin
					c_lo[c] = c_lo[c] | stop_q[k][COLOR_W - CHAN_W * (c + 1) +: CHAN_W];
				end
				if (div_hi_oh_s4[FRAC_BITS-1][k]) begin
					c_hi[c] = c_hi[c] | stop_q[k][COLOR_W - CHAN_W * (c + 1) +: CHAN_W];
				end
			end
		end
	end

	logic                  valid_s5;
	logic [FRAC_BITS-1:0]  f_s5;
	logic [CHAN_W-1:0]     clo_s5 [NUM_CHAN];
	logic signed [D_W-1:0] d_s5   [NUM_CHAN];
	logic [IDX_W-1:0]      lo_idx_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5      <= div_quo_s4[FRAC_BITS-1];
			lo_idx_s5 <= div_lo_idx_s4[FRAC_BITS-1];
			for (int c = 0; c < NUM_CHAN; c++) begin
				clo_s5[c] <= c_lo[c];
				d_s5[c]   <= $signed({1'b0, c_hi[c]}) - $signed({1'b0, c_lo[c]});
			end
		end
	end

	// stage 6: difference times fraction
	logic                     valid_s6;
	logic signed [PROD_W-1:0] prod_s6 [NUM_CHAN];
	logic [CHAN_W-1:0]        clo_s6  [NUM_CHAN];
	logic [IDX_W-1:0]         lo_idx_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_idx_s6 <= lo_idx_s5;
			for (int c = 0; c < NUM_CHAN; c++) begin
				clo_s6[c]  <= clo_s5[c];
				prod_s6[c] <= PROD_W'(d_s5[c] * $signed({1'b0, f_s5}));
			end
		end
	end

	// stage 7: c_lo + floor(d * f / 2^FRAC_BITS), the output register
	logic signed [PROD_W-1:0] blend [NUM_CHAN];
	logic [CHAN_W-1:0]        chan_s7 [NUM_CHAN];
	logic [IDX_W-1:0]         lo_idx_s7;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			blend[c] = $signed({{(PROD_W - CHAN_W){1'b0}}, clo_s6[c]})
				+ (prod_s6[c] >>> FRAC_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lo_idx_s7 <= lo_idx_s6;
			for (int c = 0; c < NUM_CHAN; c++) begin
				chan_s7[c] <= blend[c][CHAN_W-1:0];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s5 <= div_vld_s4[FRAC_BITS-1];
			valid_s6 <= valid_s5;
			valid_s7 <= valid_s6;
		end
	end

	assign m_axis_tvalid = valid_s7;
	assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, lo_idx_s7,
		chan_s7[2], chan_s7[1], chan_s7[0]};

	// last divider stage holds a single-stop segment
	logic flat_last;
	assign flat_last = (div_lo_oh_s4[FRAC_BITS-1] == div_hi_oh_s4[FRAC_BITS-1]);

	`ACR_ASSERT_NXT(a_accept_enters_s1, s_axis_tvalid && s_axis_tready, valid_s1)
	`ACR_ASSERT_IMP(a_seg_onehot, valid_s3, $onehot(lo_oh_s3) && $onehot(hi_oh_s3))
	`ACR_ASSERT_IMP(a_prog_below_gap, valid_s3, prog_s3 < gap_s3)
	`ACR_ASSERT_IMP(a_flat_zero_frac, div_vld_s4[FRAC_BITS-1] && flat_last, div_quo_s4[FRAC_BITS-1] == '0)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the altitude color ramp: directed and random pixels
// ----------------------------------------------------------------------------
// Pixels go in on the s_axis side, with random gaps and bursts. The m_axis side
// stalls at random. A predictor mirrors the register file and computes each
// color item, and a checker compares every accepted item with the oldest
// prediction. The registers are only written while no item is in flight.
module tb_top;
	import acr_pkg::*;

	localparam int FRAC_BITS   = 8;
	localparam int FRAC_ONE    = 1 << FRAC_BITS;
	localparam int LATENCY     = 6 + FRAC_BITS;
	localparam int CYCLE_LIMIT = 500000;
	localparam int MAX_WAIT    = 10;
	localparam int PRED_DEPTH  = 64;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = CFG_INDEX_W'(REG_STOP_BASE + NUM_STOPS);

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [IDX_W-1:0]  lower_stop;
	} rgb_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [ALT_W-1:0]       s_axis_tdata;  // altitude
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;  // red, green, blue, lower_stop
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [STOP_W-1:0]      cfg_data;

	// register mirror
	logic signed [ALT_W-1:0] water_lvl;
	logic [CNT_W-1:0]        stop_cnt;
	logic [STOP_W-1:0]       ramp_stop [NUM_STOPS];

	// predicted items in order, read at pred_head, written at pred_tail
	rgb_result_t pred_buf [PRED_DEPTH];
	int          pred_head;
	int          pred_tail;
	int          mismatches;
	int          colors_checked;
	int          pixels_sent;
	int          regs_written;
	int          ramp_settings;
	int          cycle_count;
	bit          no_gaps;

	altitude_color_ramp #(.FRAC_BITS(FRAC_BITS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int pred_level();
		return pred_tail - pred_head;
	endfunction

	function automatic void pred_put(rgb_result_t r);
		if (pred_level() >= PRED_DEPTH) begin
			$error("prediction buffer overflow");
			mismatches++;
		end
		pred_buf[pred_tail % PRED_DEPTH] = r;
		pred_tail++;
	endfunction

	function automatic rgb_result_t pred_take();
		rgb_result_t r;
		r = pred_buf[pred_head % PRED_DEPTH];
		pred_head++;
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors outstanding", cycle_count,
				pred_level());
			$display("** altitude_color_ramp: FAILED **");
			$finish;
		end
	end

	function automatic int draw_wait();
		if (no_gaps)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic int stop_height(int k);
		return int'($signed(ramp_stop[k][STOP_W-1:COLOR_W]));
	endfunction

	// channel 0 is red, in the top byte of the stop color
	function automatic int stop_chan(int k, int ch);
		return int'(ramp_stop[k][(NUM_CHAN-1-ch)*CHAN_W +: CHAN_W]);
	endfunction

	function automatic rgb_result_t ramp_color(logic [ALT_W-1:0] alt);
		int          height;
		int          used;
		int          lo;
		int          hi;
		int          gap;
		int          prog;
		int          frac;
		int          mix [NUM_CHAN];
		rgb_result_t r;
		height = int'($signed(alt));
		height = height - int'(water_lvl);
		used = int'(stop_cnt);
		if (used < 1)
			used = 1;
		if (used > NUM_STOPS)
			used = NUM_STOPS;
		frac = 0;
		if (height < stop_height(0)) begin
			lo = 0;
			hi = 0;
		end else begin
			lo = used - 1;
			hi = used - 1;
			// first stop above the height closes the segment, even if stops are unordered
			for (int j = 1; j < used; j++) begin
				if (height < stop_height(j)) begin
					gap = stop_height(j) - stop_height(j - 1);
					prog = height - stop_height(j - 1);
					lo = j - 1;
					hi = j;
					if (gap != 0)
						frac = (prog << FRAC_BITS) / gap;
					if (frac >= FRAC_ONE)
						frac = FRAC_ONE - 1;
					break;
				end
			end
		end
		for (int ch = 0; ch < NUM_CHAN; ch++)
			mix[ch] = (stop_chan(lo, ch) * (FRAC_ONE - frac) + stop_chan(hi, ch) * frac)
				>> FRAC_BITS;
		r.red = CHAN_W'(mix[0]);
		r.green = CHAN_W'(mix[1]);
		r.blue = CHAN_W'(mix[2]);
		r.lower_stop = IDX_W'(lo);
		return r;
	endfunction

	// output side: random stall before each item
	initial begin : color_sink
		int n;
		m_axis_tready = 1'b0;
		forever begin
			n = draw_wait();
			if (n > 0) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin : check_colors
		rgb_result_t want;
		rgb_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.red = m_axis_tdata[CHAN_W-1:0];
			got.green = m_axis_tdata[2*CHAN_W-1:CHAN_W];
			got.blue = m_axis_tdata[3*CHAN_W-1:2*CHAN_W];
			got.lower_stop = m_axis_tdata[COLOR_W +: IDX_W];
			if (pred_level() == 0) begin
				$error("color item with none expected: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pred_take();
				colors_checked++;
				if (got.red !== want.red) begin
					$error("red: expected %0d, got %0d", want.red, got.red);
					mismatches++;
				end
				if (got.green !== want.green) begin
					$error("green: expected %0d, got %0d", want.green, got.green);
					mismatches++;
				end
				if (got.blue !== want.blue) begin
					$error("blue: expected %0d, got %0d", want.blue, got.blue);
					mismatches++;
				end
				if (got.lower_stop !== want.lower_stop) begin
					$error("lower_stop: expected %0d, got %0d", want.lower_stop,
						got.lower_stop);
					mismatches++;
				end
			end
		end
	end

	// the altitude wraps to 16 bits
	task automatic send_pixel(int alt);
		int n;
		n = draw_wait();
		@(negedge clk);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ALT_W'(alt);
		do @(posedge clk); while (!s_axis_tready);
		pred_put(ramp_color(ALT_W'(alt)));
		pixels_sent++;
	endtask

	task automatic drain_pipeline();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pred_level() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [STOP_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_WATER_LEVEL)
			water_lvl = data[ALT_W-1:0];
		else if (idx == REG_STOP_COUNT)
			stop_cnt = data[CNT_W-1:0];
		else if (idx >= REG_STOP_BASE && idx < REG_UNUSED)
			ramp_stop[idx - REG_STOP_BASE] = data;
		regs_written++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_stop(int k, int alt, logic [COLOR_W-1:0] rgb);
		write_reg(CFG_INDEX_W'(REG_STOP_BASE + k), {ALT_W'(alt), rgb});
	endtask

	// reset registers: a single black stop at zero
	task automatic test_reset_state();
		send_pixel(32'h8000);
		send_pixel(32'h7FFF);
		drain_pipeline();
	endtask

	task automatic test_ramp_segments();
		write_reg(REG_WATER_LEVEL, '0);
		write_reg(REG_STOP_COUNT, STOP_W'(NUM_STOPS));
		set_stop(0, -512, 24'h0020FF);
		set_stop(1, -256, 24'h10C0A0);
		set_stop(2, 0, 24'hF0E68C);
		set_stop(3, 256, 24'h228B22);
		set_stop(4, 1024, 24'h8B4513);
		set_stop(5, 4096, 24'hFFFFFF);
		ramp_settings++;
		send_pixel(32'h8000);
		send_pixel(-512);
		send_pixel(-384);
		send_pixel(-257);
		send_pixel(0);
		send_pixel(255);
		send_pixel(4095);
		send_pixel(4096);
		send_pixel(32'h7FFF);
		drain_pipeline();
	endtask

	// count zero acts as one, count seven as six
	task automatic test_count_limits();
		write_reg(REG_STOP_COUNT, STOP_W'(0));
		send_pixel(32'h7FFF);
		send_pixel(-600);
		drain_pipeline();
		write_reg(REG_STOP_COUNT, STOP_W'(7));
		send_pixel(5000);
		drain_pipeline();
		write_reg(REG_STOP_COUNT, STOP_W'(3));
		send_pixel(500);
		drain_pipeline();
		ramp_settings += 3;
	endtask

	task automatic test_unordered_stops();
		write_reg(REG_STOP_COUNT, STOP_W'(NUM_STOPS));
		set_stop(0, 0, 24'h102030);
		set_stop(1, 1000, 24'hF0E0D0);
		set_stop(2, 500, 24'h00FF00);
		set_stop(3, 2000, 24'hFF0000);
		set_stop(4, 2000, 24'h0000FF);
		set_stop(5, 3000, 24'h808080);
		ramp_settings++;
		send_pixel(700);
		send_pixel(1500);
		send_pixel(2000);
		send_pixel(3000);
		drain_pipeline();
	endtask

	// water level extremes, widest segment, ignored register index
	task automatic test_water_level();
		write_reg(REG_WATER_LEVEL, {24'hA5A5A5, 16'h7FFF});
		send_pixel(32'h8000);
		drain_pipeline();
		write_reg(REG_WATER_LEVEL, {24'h5A5A5A, 16'h8000});
		send_pixel(32'h7FFF);
		drain_pipeline();
		write_reg(REG_WATER_LEVEL, '0);
		write_reg(REG_STOP_COUNT, {37'h1F_FFFF_FFFF, 3'd2});
		set_stop(0, 32'h8000, 24'h000000);
		set_stop(1, 32'h7FFF, 24'hFFFFFF);
		write_reg(REG_UNUSED, '1);
		write_reg('1, '1);
		ramp_settings += 3;
		send_pixel(0);
		send_pixel(32'h7FFE);
		drain_pipeline();
	endtask

	task automatic test_random_ramps(int phases, int pixels_per_ramp);
		int                  choice;
		int                  base;
		int                  h;
		int                  k;
		int                  span;
		bit                  unordered;
		logic [STOP_W-1:0]   data;
		logic [COLOR_W-1:0]  rgb;
		for (int p = 0; p < phases; p++) begin
			drain_pipeline();
			no_gaps = ($urandom_range(0, 3) == 0);
			data = STOP_W'({$urandom(), $urandom()});
			choice = $urandom_range(0, 7);
			if (choice == 0)
				data[ALT_W-1:0] = 16'h8000;
			else if (choice == 1)
				data[ALT_W-1:0] = 16'h7FFF;
			else if (choice > 3)
				data[ALT_W-1:0] = ALT_W'($urandom_range(0, 2048) - 1024);
			write_reg(REG_WATER_LEVEL, data);
			data = STOP_W'({$urandom(), $urandom()});
			data[CNT_W-1:0] = CNT_W'(p % 8);
			write_reg(REG_STOP_COUNT, data);
			unordered = ($urandom_range(0, 9) == 0);
			if ($urandom_range(0, 5) == 0)
				base = -32768;
			else
				base = int'($urandom_range(0, 40000)) - 32768;
			for (k = 0; k < NUM_STOPS; k++) begin
				if (unordered) begin
					base = int'($urandom_range(0, 65535)) - 32768;
				end else if (k > 0) begin
					choice = $urandom_range(0, 7);
					if (choice == 0)
						base += 0;
					else if (choice < 3)
						base += $urandom_range(1, 16);
					else
						base += $urandom_range(1, 4000);
					if (base > 32767 || (p % 5 == 1 && k == NUM_STOPS - 1))
						base = 32767;
				end
				rgb = COLOR_W'($urandom());
				for (int ch = 0; ch < NUM_CHAN; ch++) begin
					choice = $urandom_range(0, 7);
					if (choice == 0)
						rgb[ch*CHAN_W +: CHAN_W] = '0;
					else if (choice == 1)
						rgb[ch*CHAN_W +: CHAN_W] = '1;
				end
				set_stop(k, base, rgb);
			end
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_INDEX_W'(REG_UNUSED + $urandom_range(0, 7)),
					STOP_W'({$urandom(), $urandom()}));
			ramp_settings++;
			for (int i = 0; i < pixels_per_ramp; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					send_pixel($urandom());
				end else begin
					// aim near a stop so that every segment and boundary gets traffic
					k = $urandom_range(0, NUM_STOPS - 1);
					span = ($urandom_range(0, 1) == 0) ? 64 : 2048;
					h = stop_height(k) + int'($urandom_range(0, 2 * span)) - span;
					send_pixel(h + int'(water_lvl));
				end
			end
		end
		drain_pipeline();
		no_gaps = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		no_gaps = 1'b0;
		pred_head = 0;
		pred_tail = 0;
		water_lvl = '0;
		stop_cnt = CNT_W'(1);
		for (int k = 0; k < NUM_STOPS; k++)
			ramp_stop[k] = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_ramp_segments();
		test_count_limits();
		test_unordered_stops();
		test_water_level();
		test_random_ramps(32, 48);

		repeat (LATENCY + 8) @(posedge clk);
		$display("sent %0d pixels over %0d ramp settings, %0d register writes", pixels_sent,
			ramp_settings, regs_written);
		$display("checked %0d color items, %0d mismatches", colors_checked, mismatches);
		if (mismatches == 0 && pred_level() == 0) begin
			$display("** altitude_color_ramp: PASSED **");
		end else begin
			if (pred_level() != 0)
				$error("%0d expected color items never came out", pred_level());
			$display("** altitude_color_ramp: FAILED **");
		end
		$finish;
	end

endmodule
